>>> rtl/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg: shared types and functions for the PRESENT-128 encrypt pipeline
// S-box, bit permutation, key schedule step and per-stage payload type.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int BLOCK_W   = 64;
    localparam int KEY_W     = 128;
    localparam int RC_W      = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = CFG_IDX_W'(1);

    typedef logic [3:0] t_nibble;

    localparam t_nibble SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    typedef struct packed {
        logic [BLOCK_W-1:0] state;
        logic [KEY_W-1:0]   key;
    } t_stage;

    function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = SBOX[x[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int b = 0; b < BLOCK_W; b++) begin
            if (b == BLOCK_W - 1) begin
                r[b] = x[b];
            end else begin
                r[(b * 16) % (BLOCK_W - 1)] = x[b];
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k,
                                                  input logic [RC_W-1:0] rc);
        logic [BLOCK_W-1:0] hi;
        logic [BLOCK_W-1:0] lo;
        logic [BLOCK_W-1:0] nhi;
        logic [BLOCK_W-1:0] nlo;
        hi  = k[KEY_W-1:BLOCK_W];
        lo  = k[BLOCK_W-1:0];
        nhi = {hi[2:0], lo[BLOCK_W-1:3]};
        nlo = {lo[2:0], hi[BLOCK_W-1:3]};
        nhi[63:60] = SBOX[nhi[63:60]];
        nhi[59:56] = SBOX[nhi[59:56]];
        nlo[63:62] = nlo[63:62] ^ rc[1:0];
        nhi[2:0]   = nhi[2:0] ^ rc[4:2];
        return {nhi, nlo};
    endfunction

endpackage

>>> rtl/present128_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present128_block_encrypt: PRESENT block encryption, 128-bit key
// Throughput: one block per cycle while the output is not stalled; one round register stage per round.
// A stall at the output holds every stage of the pipeline.
// Reset clears the stage valid bits and sets both key registers to zero.
// ----------------------------------------------------------------------------
module present128_block_encrypt #(
    parameter int ROUNDS = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [prs_pkg::BLOCK_W-1:0]     i_plaintext,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [prs_pkg::BLOCK_W-1:0]     o_ciphertext,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prs_pkg::BLOCK_W-1:0]     i_cfg_data
);

    logic [prs_pkg::BLOCK_W-1:0] r_key_upper;
    logic [prs_pkg::BLOCK_W-1:0] r_key_lower;
    logic                        w_en;
    logic                        w_valid [ROUNDS+1];
    prs_pkg::t_stage             w_data  [ROUNDS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                prs_pkg::REG_KEY_UPPER: r_key_upper <= i_cfg_data;
                prs_pkg::REG_KEY_LOWER: r_key_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the whole pipeline while the finished block is stalled
    assign w_en       = !(w_valid[ROUNDS] && i_out_stall);
    assign o_in_stall = !w_en;

    assign w_valid[0]      = i_in_valid;
    assign w_data[0].state = i_plaintext;
    assign w_data[0].key   = {r_key_upper, r_key_lower};

    for (genvar k = 0; k < ROUNDS; k++) begin : g_round
        prs_round #(
            .RC (k + 1)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    assign o_out_valid  = w_valid[ROUNDS];
    assign o_ciphertext = w_data[ROUNDS].state
                        ^ w_data[ROUNDS].key[prs_pkg::KEY_W-1:prs_pkg::BLOCK_W];

endmodule

>>> rtl/prs_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_round: one registered PRESENT round with its key schedule step
// Add round key, substitute, permute; advance the carried key register.
// ----------------------------------------------------------------------------
module prs_round #(
    parameter int RC = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  prs_pkg::t_stage i_data,
    output logic            o_valid,
    output prs_pkg::t_stage o_data
);

    localparam logic [prs_pkg::RC_W-1:0] RC_BITS = prs_pkg::RC_W'(RC);

    logic            r_valid;
    prs_pkg::t_stage r_data;
    prs_pkg::t_stage n_data;
    logic [prs_pkg::BLOCK_W-1:0] w_mix;

    always_comb begin
        w_mix        = i_data.state ^ i_data.key[prs_pkg::KEY_W-1:prs_pkg::BLOCK_W];
        n_data.state = prs_pkg::perm_layer(prs_pkg::sub_layer(w_mix));
        n_data.key   = prs_pkg::key_step(i_data.key, RC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> dv/present128_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present128_cipher_checker: scoreboard for the PRESENT-128 encrypt pipeline
// Watches the key write, plaintext and ciphertext channels. For each accepted
// plaintext it computes the ciphertext under the key held at that moment and
// queues it. Each accepted ciphertext is compared with the oldest queued one.
// Reports a failure count and the number of ciphertexts still outstanding.
// ----------------------------------------------------------------------------
module present128_cipher_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [prs_pkg::BLOCK_W-1:0]     i_plaintext,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [prs_pkg::BLOCK_W-1:0]     i_ciphertext,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [prs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prs_pkg::BLOCK_W-1:0]     i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int NUM_ROUNDS = 31;

    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    logic [63:0] key_hi = '0;
    logic [63:0] key_lo = '0;
    logic [63:0] expected_ciphertexts [$];
    int          mismatches = 0;
    int          outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    function automatic logic [63:0] substitute_nibbles(input logic [63:0] x);
        logic [63:0] r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = NIBBLE_SUB[x[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [63:0] permute_bits(input logic [63:0] x);
        logic [63:0] r;
        for (int b = 0; b < 64; b++) begin
            r[(b == 63) ? 63 : (b * 16) % 63] = x[b];
        end
        return r;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [4:0] counter);
        logic [127:0] n;
        n = {k[66:0], k[127:67]};
        n[127:124] = NIBBLE_SUB[n[127:124]];
        n[123:120] = NIBBLE_SUB[n[123:120]];
        n[66:62]   = n[66:62] ^ counter;
        return n;
    endfunction

    function automatic logic [63:0] encrypt_block(input logic [63:0] plain,
                                                  input logic [127:0] key);
        logic [127:0] k;
        logic [63:0]  s;
        k = key;
        s = plain;
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
            s = permute_bits(substitute_nibbles(s ^ k[127:64]));
            k = next_round_key(k, 5'(r));
        end
        return s ^ k[127:64];
    endfunction

    always @(posedge i_clk) begin : scoreboard
        logic [63:0] expected;
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            expected_ciphertexts.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_ciphertexts.push_back(encrypt_block(i_plaintext, {key_hi, key_lo}));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_ciphertexts.size() == 0) begin
                    $error("ciphertext %h with no block outstanding", i_ciphertext);
                    mismatches++;
                end else begin
                    expected = expected_ciphertexts.pop_front();
                    if (i_ciphertext !== expected) begin
                        $error("ciphertext mismatch: expected %h, actual %h",
                               expected, i_ciphertext);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    prs_pkg::REG_KEY_UPPER: key_hi = i_cfg_data;
                    prs_pkg::REG_KEY_LOWER: key_lo = i_cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding = expected_ciphertexts.size();
    end

endmodule

>>> dv/present128_block_encrypt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present128_block_encrypt_tb: top-level bench for the PRESENT-128 encryptor
// Drives plaintext blocks and key writes, randomizes source idle and sink
// stall across three pressure phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module present128_block_encrypt_tb;

    localparam int PIPE_DEPTH = 31;

    localparam logic [prs_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = prs_pkg::CFG_IDX_W'(2);
    localparam logic [prs_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = prs_pkg::CFG_IDX_W'(3);

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [prs_pkg::BLOCK_W-1:0]        plaintext = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [prs_pkg::BLOCK_W-1:0]        ciphertext;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [prs_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [prs_pkg::BLOCK_W-1:0]        cfg_data = '0;

    int fail_count;
    int pending;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    present128_block_encrypt i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_plaintext  (plaintext),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_ciphertext (ciphertext),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    present128_cipher_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_plaintext  (plaintext),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_ciphertext (ciphertext),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    task automatic send_block(input logic [prs_pkg::BLOCK_W-1:0] block);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        plaintext <= block;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_key_reg(input logic [prs_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [prs_pkg::BLOCK_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [prs_pkg::BLOCK_W-1:0] random_block();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic change_key();
        case ($urandom_range(4))
            0: begin
                write_key_reg(prs_pkg::REG_KEY_UPPER, {$urandom, $urandom});
                write_key_reg(prs_pkg::REG_KEY_LOWER, {$urandom, $urandom});
            end
            1: write_key_reg(prs_pkg::REG_KEY_UPPER, {$urandom, $urandom});
            2: write_key_reg(prs_pkg::REG_KEY_LOWER, {$urandom, $urandom});
            3: begin
                write_key_reg(prs_pkg::REG_KEY_UPPER, $urandom_range(1) ? '1 : '0);
                write_key_reg(prs_pkg::REG_KEY_LOWER, $urandom_range(1) ? '1 : '0);
            end
            default: begin
                write_key_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                              {$urandom, $urandom});
                write_key_reg(prs_pkg::REG_KEY_LOWER, {$urandom, $urandom});
            end
        endcase
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_block('0);
        send_block('1);
        send_block(64'h1);
        send_block(64'h8000_0000_0000_0000);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'hAAAA_AAAA_AAAA_AAAA);
        drain_pipeline();
        write_key_reg(prs_pkg::REG_KEY_UPPER, '1);
        write_key_reg(prs_pkg::REG_KEY_LOWER, '1);
        send_block('0);
        send_block('1);
        drain_pipeline();
        write_key_reg(prs_pkg::REG_KEY_UPPER, '0);
        send_block(64'h0123_4567_89AB_CDEF);
        drain_pipeline();
        write_key_reg(REG_SPARE_2, {$urandom, $urandom});
        write_key_reg(REG_SPARE_3, {$urandom, $urandom});
        send_block({$urandom, $urandom});
        drain_pipeline();
        write_key_reg(prs_pkg::REG_KEY_LOWER, '0);
        send_block('1);
        drain_pipeline();
        write_key_reg(prs_pkg::REG_KEY_UPPER, 64'hFEDC_BA98_7654_3210);
        write_key_reg(prs_pkg::REG_KEY_LOWER, 64'h0F1E_2D3C_4B5A_6978);
        send_block(64'h0123_4567_89AB_CDEF);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 37;
                    sink_stall_pct = 87;
                end
                1: begin
                    src_idle_pct   = 87;
                    sink_stall_pct = 37;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                drain_pipeline();
                change_key();
                repeat (61) send_block(random_block());
            end
        end

        drain_pipeline();
        repeat (PIPE_DEPTH + 10) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
